[hdl/rstm_pkg.sv]
// Shared widths, codes and numerology helper functions for the radio slot time mapper.
package rstm_pkg;

	localparam int SLOT_W = 18;
	localparam int TIME_W = 64;
	localparam int NUM_W = 3;
	localparam int SFN_W = 10;
	localparam int SF_W = 4;
	localparam int SLOT_NS_W = 20;
	localparam int DIV_STEPS = TIME_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [SLOT_W-1:0] CYC_BASE = 18'd10240;
	localparam logic [12:0] RECIP_TEN = 13'd6554;
	localparam logic [NUM_W-1:0] NUM_MAX = 3'd4;

	typedef enum logic [1:0] {
		REQ_STORE = 2'd0,
		REQ_READ = 2'd1,
		REQ_SLOT_TO_TIME = 2'd2,
		REQ_TIME_TO_SLOT = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_ANCHOR = 3'd1,
		ST_BAD_SLOT = 3'd2,
		ST_NUM_MISMATCH = 3'd3,
		ST_ZERO_TIME = 3'd4
	} status_t;

	// Numerology codes above the largest supported one behave as the largest.
	function automatic logic [NUM_W-1:0] eff_num(input logic [NUM_W-1:0] n);
		return (n > NUM_MAX) ? NUM_MAX : n;
	endfunction

	// Number of slots in the 1024-frame system cycle.
	function automatic logic [SLOT_W-1:0] cyc_len(input logic [NUM_W-1:0] n);
		return CYC_BASE << n;
	endfunction

	// Slot duration in nanoseconds; the microsecond figure is truncated first.
	function automatic logic [SLOT_NS_W-1:0] slot_ns(input logic [NUM_W-1:0] n);
		logic [SLOT_NS_W-1:0] v;
		case (n)
			3'd0: v = 20'd1000000;
			3'd1: v = 20'd500000;
			3'd2: v = 20'd250000;
			3'd3: v = 20'd125000;
			default: v = 20'd62000;
		endcase
		return v;
	endfunction

	// Slot index modulo the cycle. The cycle is five times a power of two, so only
	// the bits above that power need a reduction modulo five.
	function automatic logic [SLOT_W-1:0] mod_cycle(input logic [SLOT_W-1:0] slot,
			input logic [NUM_W-1:0] n);
		logic [4:0] k;
		logic [6:0] hi;
		logic [3:0] r4;
		logic [2:0] r;
		logic [SLOT_W-1:0] low_mask;
		k = 5'd11 + 5'(n);
		hi = 7'(slot >> k);
		r = 3'd0;
		for (int i = 6; i >= 0; i--) begin
			r4 = {r, hi[i]};
			if (r4 >= 4'd5) begin
				r4 = r4 - 4'd5;
			end
			r = r4[2:0];
		end
		low_mask = (18'd1 << k) - 18'd1;
		return (18'(r) << k) | (slot & low_mask);
	endfunction

endpackage

[hdl/rstm_div.sv]
// Bit-serial restoring divider that keeps the quotient modulo the slot cycle.
module rstm_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               go,
	input  logic [rstm_pkg::TIME_W-1:0]        dividend,
	input  logic [rstm_pkg::SLOT_NS_W-1:0]     divisor,
	input  logic [rstm_pkg::SLOT_W-1:0]        modulus,
	output logic                               done,
	output logic [rstm_pkg::SLOT_W-1:0]        residue
);

	logic [rstm_pkg::SLOT_NS_W-1:0] rem_q;
	logic [rstm_pkg::SLOT_NS_W-1:0] dsr_q;
	logic [rstm_pkg::TIME_W-1:0]    dvd_q;
	logic [rstm_pkg::SLOT_W-1:0]    mod_q;
	logic [rstm_pkg::SLOT_W-1:0]    qm_q;
	logic [rstm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;

	logic [rstm_pkg::SLOT_NS_W:0]   trial;
	logic                           q_bit;
	logic [rstm_pkg::SLOT_NS_W-1:0] rem_nxt;
	logic [rstm_pkg::SLOT_W:0]      qm2;
	logic [rstm_pkg::SLOT_W-1:0]    qm_nxt;

	// One quotient bit per cycle, most significant first; the running value of
	// the quotient modulo the cycle doubles and takes in each new bit.
	always_comb begin
		trial = {rem_q, dvd_q[rstm_pkg::TIME_W-1]};
		q_bit = (trial >= {1'b0, dsr_q});
		rem_nxt = q_bit ? rstm_pkg::SLOT_NS_W'(trial - {1'b0, dsr_q})
			: trial[rstm_pkg::SLOT_NS_W-1:0];
		qm2 = {qm_q, q_bit};
		qm_nxt = (qm2 >= {1'b0, mod_q}) ? rstm_pkg::SLOT_W'(qm2 - {1'b0, mod_q})
			: qm2[rstm_pkg::SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			dsr_q <= '0;
			dvd_q <= '0;
			mod_q <= '0;
			qm_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				rem_q <= '0;
				dsr_q <= divisor;
				dvd_q <= dividend;
				mod_q <= modulus;
				qm_q <= '0;
				cnt_q <= rstm_pkg::DIV_CNT_W'(rstm_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				rem_q <= rem_nxt;
				dvd_q <= {dvd_q[rstm_pkg::TIME_W-2:0], 1'b0};
				qm_q <= qm_nxt;
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == rstm_pkg::DIV_CNT_W'(1));
			end
		end
	end

	assign done = done_q;
	assign residue = qm_q;

endmodule

[hdl/radio_slot_time_mapper.sv]
// Top level of the radio slot time mapper: anchor store, sequencer and shared 64-bit adder.
// The result strobe comes from state PREP with no anchor, from ATIME for read anchor or
// a query refused at the anchor step, from SADD for slot to time and from TDIV for time to slot,
// where it waits on the bit-serial divider taking one quotient bit a cycle over 64 bits.
// A store gives no result; busy holds in PREP, STORE and STORE2 (PREP, STORE if ignored) and
// spans accepting edge to result edge, so one beat at a time, and results cannot be held off.
module radio_slot_time_mapper #(
	parameter int TS_WIDTH = 50
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               cfg_we,
	input  logic [rstm_pkg::NUM_W-1:0]         cfg_wdata,
	input  logic [1:0]                         req_type,
	input  logic [rstm_pkg::SLOT_W-1:0]        slot_count,
	input  logic                               slot_valid,
	input  logic [rstm_pkg::NUM_W-1:0]         slot_numerology,
	input  logic [rstm_pkg::TIME_W-1:0]        time_ns,
	input  logic [rstm_pkg::TIME_W-1:0]        now_ns,
	output logic                               done,
	output logic [2:0]                         status,
	output logic [rstm_pkg::SLOT_W-1:0]        out_slot_count,
	output logic [rstm_pkg::TIME_W-1:0]        out_time_ns
);

	// Reset clears the anchor (no anchor), the numerology register to 0 and the sequencer to idle.
	localparam int TSW = TS_WIDTH;
	localparam int TW = rstm_pkg::TIME_W;
	localparam int SW = rstm_pkg::SLOT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_STORE,
		S_STORE2,
		S_ATIME,
		S_SDIFF,
		S_SMUL,
		S_SADD,
		S_TDIFF,
		S_TABS,
		S_TDIV
	} state_t;

	state_t state_q;

	// Captured beat.
	rstm_pkg::req_t                 req_q;
	logic [SW-1:0]                  slot_q;
	logic                           valid_q;
	logic [rstm_pkg::NUM_W-1:0]     sn_q;
	logic [TW-1:0]                  time_q;
	logic [TW-1:0]                  now_q;

	// Configuration and anchor. The anchor is all zero when none has been stored.
	logic [rstm_pkg::NUM_W-1:0]     numerology_q;
	logic [rstm_pkg::SFN_W-1:0]     anc_sfn_q;
	logic [rstm_pkg::SF_W-1:0]      anc_sf_q;
	logic [TSW-1:0]                 anc_ts_q;

	// Working registers of the sequencer.
	logic [SW-1:0]                  smod_q;
	logic [SW-1:0]                  aslot_q;
	logic                           adj_add_q;
	logic                           adj_sub_q;
	logic [TW-1:0]                  atime_q;
	logic [TW-1:0]                  diff_q;
	logic [SW-1:0]                  d_q;
	logic [37:0]                    prod_q;
	logic                           neg_q;
	logic [13:0]                    st_t_q;

	// Result registers.
	logic                           done_q;
	rstm_pkg::status_t              status_q;
	logic [SW-1:0]                  oslot_q;
	logic [TW-1:0]                  otime_q;

	logic [rstm_pkg::NUM_W-1:0]     n_w;
	logic [SW-1:0]                  cyc_w;
	logic [rstm_pkg::SLOT_NS_W-1:0] ns_w;
	logic                           anchor_none;
	logic [13:0]                    abase_w;
	logic [TSW:0]                   dlt_w;
	logic [TSW:0]                   ndlt_w;
	logic [TSW:0]                   half_c;
	logic [TW-1:0]                  period_c;
	logic [TW-1:0]                  cand_w;
	logic [26:0]                    recip_w;
	logic [SW:0]                    d19_w;
	logic [SW-1:0]                  m_w;
	logic                           far_w;
	logic [37:0]                    prod_w;
	logic [SW:0]                    osum_w;
	logic [SW-1:0]                  ored_w;

	logic [TW-1:0]                  alu_a;
	logic [TW-1:0]                  alu_b;
	logic                           alu_sub;
	logic [TW-1:0]                  alu_y;

	logic                           div_go;
	logic                           div_done;
	logic [SW-1:0]                  div_res;

	// A store works in the numerology of its slot; every query works in the
	// numerology of the register, which a slot to time query must match anyway.
	always_comb begin
		n_w = rstm_pkg::eff_num((req_q == rstm_pkg::REQ_STORE) ? sn_q : numerology_q);
		cyc_w = rstm_pkg::cyc_len(n_w);
		ns_w = rstm_pkg::slot_ns(n_w);
		anchor_none = (anc_sfn_q == '0) && (anc_sf_q == '0) && (anc_ts_q == '0);
		// Frame times ten plus subframe, by shift and add.
		abase_w = (14'(anc_sfn_q) << 3) + (14'(anc_sfn_q) << 1) + 14'(anc_sf_q);
	end

	// Anchor time rebuild. The candidate shares its upper bits with now, so its
	// distance to now is just the difference of the low timestamp bits.
	assign half_c = {2'b01, {(TSW-1){1'b0}}};
	assign period_c = {{(TW-TSW-1){1'b0}}, 1'b1, {TSW{1'b0}}};
	assign cand_w = {now_q[TW-1:TSW], anc_ts_q};
	assign dlt_w = {1'b0, anc_ts_q} - {1'b0, now_q[TSW-1:0]};
	assign ndlt_w = (~dlt_w) + 1'b1;

	// Division of the subframe count within the cycle by ten through a reciprocal; exact
	// for every value below the number of subframes in the cycle.
	assign recip_w = 27'(st_t_q) * 27'(rstm_pkg::RECIP_TEN);

	// Slot to time: wrap-aware slot distance, then its magnitude times the slot length.
	assign d19_w = {1'b0, smod_q} + {1'b0, cyc_w} - {1'b0, aslot_q};
	assign far_w = (d_q >= (cyc_w >> 1));
	assign m_w = far_w ? (cyc_w - d_q) : d_q;
	assign prod_w = 38'(m_w) * 38'(ns_w);

	// Time to slot: move from the anchor slot by the quotient modulo the cycle.
	always_comb begin
		if (neg_q) begin
			osum_w = {1'b0, aslot_q} + {1'b0, cyc_w} - {1'b0, div_res};
		end else begin
			osum_w = {1'b0, aslot_q} + {1'b0, div_res};
		end
		ored_w = (osum_w >= {1'b0, cyc_w}) ? SW'(osum_w - {1'b0, cyc_w}) : osum_w[SW-1:0];
	end

	// The one 64-bit adder, shared by every 64-bit sum of the sequence.
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_ATIME: begin
				alu_a = cand_w;
				alu_b = (adj_add_q || adj_sub_q) ? period_c : '0;
				alu_sub = adj_sub_q;
			end
			S_SADD: begin
				alu_a = atime_q;
				alu_b = {{(TW-38){1'b0}}, prod_q};
				alu_sub = neg_q;
			end
			S_TDIFF: begin
				alu_a = time_q;
				alu_b = atime_q;
				alu_sub = 1'b1;
			end
			S_TABS: begin
				alu_a = diff_q[TW-1] ? '0 : diff_q;
				alu_b = diff_q[TW-1] ? diff_q : '0;
				alu_sub = diff_q[TW-1];
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
		alu_y = alu_a + (alu_b ^ {TW{alu_sub}}) + TW'(alu_sub);
	end

	assign div_go = (state_q == S_TABS);

	rstm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (alu_y),
		.divisor  (ns_w),
		.modulus  (cyc_w),
		.done     (div_done),
		.residue  (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= rstm_pkg::REQ_STORE;
			slot_q <= '0;
			valid_q <= 1'b0;
			sn_q <= '0;
			time_q <= '0;
			now_q <= '0;
			numerology_q <= '0;
			anc_sfn_q <= '0;
			anc_sf_q <= '0;
			anc_ts_q <= '0;
			smod_q <= '0;
			aslot_q <= '0;
			adj_add_q <= 1'b0;
			adj_sub_q <= 1'b0;
			atime_q <= '0;
			diff_q <= '0;
			d_q <= '0;
			prod_q <= '0;
			neg_q <= 1'b0;
			st_t_q <= '0;
			done_q <= 1'b0;
			status_q <= rstm_pkg::ST_OK;
			oslot_q <= '0;
			otime_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				numerology_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= rstm_pkg::req_t'(req_type);
						slot_q <= slot_count;
						valid_q <= slot_valid;
						sn_q <= slot_numerology;
						time_q <= time_ns;
						now_q <= now_ns;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					smod_q <= rstm_pkg::mod_cycle(slot_q, n_w);
					aslot_q <= SW'(abase_w) << n_w;
					adj_sub_q <= !dlt_w[TSW] && (dlt_w > half_c);
					adj_add_q <= dlt_w[TSW] && (ndlt_w > half_c);
					if (req_q == rstm_pkg::REQ_STORE) begin
						state_q <= S_STORE;
					end else if (anchor_none) begin
						done_q <= 1'b1;
						status_q <= rstm_pkg::ST_NO_ANCHOR;
						oslot_q <= '0;
						otime_q <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ATIME;
					end
				end
				S_STORE: begin
					// Only the first slot of a subframe moves the anchor.
					st_t_q <= 14'(smod_q >> n_w);
					if (valid_q && ((smod_q & ((18'd1 << n_w) - 18'd1)) == '0)) begin
						state_q <= S_STORE2;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_STORE2: begin
					anc_sfn_q <= recip_w[25:16];
					anc_sf_q <= 4'(14'(st_t_q) - ((14'(recip_w[25:16]) << 3)
						+ (14'(recip_w[25:16]) << 1)));
					anc_ts_q <= time_q[TSW-1:0];
					state_q <= S_IDLE;
				end
				S_ATIME: begin
					atime_q <= alu_y;
					case (req_q)
						rstm_pkg::REQ_READ: begin
							done_q <= 1'b1;
							status_q <= rstm_pkg::ST_OK;
							oslot_q <= aslot_q;
							otime_q <= alu_y;
							state_q <= S_IDLE;
						end
						rstm_pkg::REQ_SLOT_TO_TIME: begin
							if (!valid_q) begin
								done_q <= 1'b1;
								status_q <= rstm_pkg::ST_BAD_SLOT;
								oslot_q <= '0;
								otime_q <= '0;
								state_q <= S_IDLE;
							end else if (sn_q != numerology_q) begin
								done_q <= 1'b1;
								status_q <= rstm_pkg::ST_NUM_MISMATCH;
								oslot_q <= '0;
								otime_q <= '0;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_SDIFF;
							end
						end
						rstm_pkg::REQ_TIME_TO_SLOT: begin
							if (time_q == '0) begin
								done_q <= 1'b1;
								status_q <= rstm_pkg::ST_ZERO_TIME;
								oslot_q <= '0;
								otime_q <= '0;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_TDIFF;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SDIFF: begin
					d_q <= (d19_w >= {1'b0, cyc_w}) ? SW'(d19_w - {1'b0, cyc_w})
						: d19_w[SW-1:0];
					state_q <= S_SMUL;
				end
				S_SMUL: begin
					prod_q <= prod_w;
					neg_q <= far_w;
					state_q <= S_SADD;
				end
				S_SADD: begin
					done_q <= 1'b1;
					status_q <= rstm_pkg::ST_OK;
					oslot_q <= smod_q;
					otime_q <= alu_y;
					state_q <= S_IDLE;
				end
				S_TDIFF: begin
					diff_q <= alu_y;
					state_q <= S_TABS;
				end
				S_TABS: begin
					// The divider takes the magnitude straight from the adder.
					neg_q <= diff_q[TW-1];
					state_q <= S_TDIV;
				end
				S_TDIV: begin
					if (div_done) begin
						done_q <= 1'b1;
						status_q <= rstm_pkg::ST_OK;
						oslot_q <= ored_w;
						otime_q <= time_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign out_slot_count = oslot_q;
	assign out_time_ns = otime_q;

endmodule
